FILE: sv/pqrm_pkg.sv
package pqrm_pkg;

    localparam int PQRM_DEPTH_DEFAULT = 16;

    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                 ins_en;
        logic                 rem_en;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
    } pqrm_cmd_t;

endpackage

FILE: sv/pqrm_cell.sv
module pqrm_cell
    import pqrm_pkg::*;
(
    input  logic                 clk,
    input  pqrm_cmd_t            cmd,
    input  logic                 occupied,
    input  logic                 left_greater,
    input  logic [PRIO_W-1:0]    left_prio,
    input  logic [PAYLOAD_W-1:0] left_payload,
    input  logic [PRIO_W-1:0]    right_prio,
    input  logic [PAYLOAD_W-1:0] right_payload,
    output logic                 greater,
    output logic [PRIO_W-1:0]    prio,
    output logic [PAYLOAD_W-1:0] payload
);

    logic [PRIO_W-1:0]    prio_reg;
    logic [PRIO_W-1:0]    prio_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;

    // strict compare keeps equal priorities in arrival order
    assign greater = !occupied || (prio_reg > cmd.prio);

    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (cmd.rem_en)
        begin
            prio_next    = right_prio;
            payload_next = right_payload;
        end
        else if (cmd.ins_en && greater)
        begin
            if (left_greater)
            begin
                prio_next    = left_prio;
                payload_next = left_payload;
            end
            else
            begin
                prio_next    = cmd.prio;
                payload_next = cmd.payload;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

FILE: sv/priority_queue_remove_min.sv
// channel   | dir | tdata (low bit up)                         | tuser
// s_axis    | in  | priority_req[15:0], payload[47:16]         | action
// m_axis    | out | out_priority[15:0], out_payload[47:16],    | status
//           |     | fill_count[52:48], zero pad to 56 bits     |
//
// one transaction per cycle unless stalled: every cell compares against the new
// priority at once, the chain shifts by one place, and the result is ready next cycle
// entries stay sorted by priority, ties in arrival order; the head cell is the minimum
// reset clears the entry count and the output valid flag; cell contents need none
// a stalled result holds in the output register; the next transaction is taken only
// once m_axis_tready frees it
module priority_queue_remove_min
    import pqrm_pkg::*;
#(
    parameter int DEPTH = PQRM_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // priority_req, payload
    input  logic                  s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_priority, out_payload, fill_count
    output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [STATUS_W-1:0]   out_user_reg;
    logic [STATUS_W-1:0]   out_user_next;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic                  ins_ok;
    logic                  rem_ok;
    logic [PRIO_W-1:0]     in_prio;
    logic [PAYLOAD_W-1:0]  in_payload;
    pqrm_cmd_t             cmd;
    logic [CNT_W+FILL_W-1:0] count_ext;
    logic [FILL_W-1:0]     fill;

    logic                  cell_greater [DEPTH];
    logic [PRIO_W-1:0]     cell_prio    [DEPTH];
    logic [PAYLOAD_W-1:0]  cell_payload [DEPTH];

    assign in_prio    = s_axis_tdata[PRIO_W-1:0];
    assign in_payload = s_axis_tdata[PRIO_W+PAYLOAD_W-1:PRIO_W];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign ins_ok   = accept && (s_axis_tuser == ACT_INSERT) && !is_full;
    assign rem_ok   = accept && (s_axis_tuser == ACT_REMOVE) && !is_empty;

    assign cmd.ins_en  = ins_ok;
    assign cmd.rem_en  = rem_ok;
    assign cmd.prio    = in_prio;
    assign cmd.payload = in_payload;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                 l_greater;
            logic [PRIO_W-1:0]    l_prio;
            logic [PAYLOAD_W-1:0] l_payload;
            logic [PRIO_W-1:0]    r_prio;
            logic [PAYLOAD_W-1:0] r_payload;

            if (gi == 0)
            begin : g_first
                assign l_greater = 1'b0;
                assign l_prio    = in_prio;
                assign l_payload = in_payload;
            end
            else
            begin : g_mid
                assign l_greater = cell_greater[gi-1];
                assign l_prio    = cell_prio[gi-1];
                assign l_payload = cell_payload[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_prio    = '0;
                assign r_payload = '0;
            end
            else
            begin : g_inner
                assign r_prio    = cell_prio[gi+1];
                assign r_payload = cell_payload[gi+1];
            end

            pqrm_cell u_cell (
                .clk           (clk),
                .cmd           (cmd),
                .occupied      (CNT_W'(gi) < count_reg),
                .left_greater  (l_greater),
                .left_prio     (l_prio),
                .left_payload  (l_payload),
                .right_prio    (r_prio),
                .right_payload (r_payload),
                .greater       (cell_greater[gi]),
                .prio          (cell_prio[gi]),
                .payload       (cell_payload[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rem_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext = {{FILL_W{1'b0}}, count_next};
    assign fill      = count_ext[FILL_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[PRIO_W+PAYLOAD_W+FILL_W-1:PRIO_W+PAYLOAD_W] = fill;
            if (s_axis_tuser == ACT_INSERT)
            begin
                out_user_next = is_full ? ST_FULL : ST_OK;
            end
            else if (is_empty)
            begin
                out_user_next = ST_EMPTY;
            end
            else
            begin
                out_user_next = ST_OK;
                out_data_next[PRIO_W-1:0]                = cell_prio[0];
                out_data_next[PRIO_W+PAYLOAD_W-1:PRIO_W] = cell_payload[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // the entry count never runs past the chain length
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // an insert that fits grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    // a remove from a non-empty queue yields a good result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_ok |=> m_axis_tvalid && m_axis_tuser == ST_OK)
        else $error("remove result missing or wrong status");

    // the head cell always holds a minimum over the first two entries
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1])
        else $error("cell chain out of order");

endmodule
